FILE: design/sffrf_pkg.sv
// Package for the status frame filter receive FIFO.
// Holds shared types and constants; no dependencies.
package sffrf_pkg;

    typedef enum logic [1:0] {
        ACT_BYTE = 2'd0,
        ACT_TICK = 2'd1,
        ACT_READ = 2'd2,
        ACT_NONE = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        LINK_NONE  = 2'd0,
        LINK_READY = 2'd1,
        LINK_CONN  = 2'd2
    } link_t;

    typedef enum logic [1:0] {
        RS_OK      = 2'd0,
        RS_NOCONN  = 2'd1,
        RS_FEW     = 2'd2,
        RS_NOTREAD = 2'd3
    } rstat_t;

    typedef enum logic [2:0] {
        EV_NONE    = 3'd0,
        EV_FULL    = 3'd1,
        EV_STARTUP = 3'd2,
        EV_ACCEPT  = 3'd3,
        EV_RELEASE = 3'd4
    } event_t;

    typedef enum logic [1:0] {
        ST_IDLE = 2'd0,
        ST_READ = 2'd1,
        ST_OUT  = 2'd2
    } state_t;

    localparam logic [7:0] STX_BYTE = 8'h02;
    localparam logic [7:0] IND_BYTE = 8'h69;
    localparam logic [7:0] OP_READY = 8'h25;
    localparam logic [7:0] OP_LINK_EST = 8'h0C;
    localparam logic [7:0] ETX_BYTE = 8'h03;
    localparam logic [7:0] OP_TRANSPARENT = 8'h11;
    localparam logic [7:0] OP_RELEASED = 8'h0E;
    localparam logic [15:0] TIMEOUT_RESET = 16'd9999;
    localparam logic [6:0] READ_MAX = 7'd64;

endpackage

FILE: design/sffrf_ram.sv
// Generic single-port-write, single-read RAM with registered read data.
// No dependencies.
module sffrf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);
    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end
endmodule

FILE: design/status_frame_filter_rx_fifo_core.sv
// Top level of the status frame filter receive FIFO.
// Depends on sffrf_pkg and sffrf_ram.
// A byte, tick or failed read is accepted while s_ready is high and its item is valid the cycle after.
// A successful read of N bytes gives N items, each waiting on the registered RAM read of its
// byte, and holds off the input through the read and ST_OUT; back-pressure stalls the read.
// Synchronous active-low reset clears all control state; the RAM holds no reset value.
module status_frame_filter_rx_fifo_core #(
    parameter int FIFO_DEPTH = 256
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [15:0] cfg_wdata,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_action,
    input  logic [7:0]  s_rx_byte,
    input  logic        s_framing_error,
    input  logic [6:0]  s_read_count,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_link_state,
    output logic [7:0]  m_read_data,
    output logic [1:0]  m_read_status,
    output logic [2:0]  m_event_res,
    output logic [8:0]  m_readable_count,
    output logic        m_last
);
    localparam int AW = $clog2(FIFO_DEPTH);
    localparam int CW = $clog2(FIFO_DEPTH + 1);
    localparam logic [CW-1:0] DEPTH_C = CW'(FIFO_DEPTH);
    localparam logic [AW-1:0] LAST_A = AW'(FIFO_DEPTH - 1);

    sffrf_pkg::state_t state_reg, state_next;
    logic [AW-1:0] wp_reg, rp_reg;
    logic [CW-1:0] readable_reg, pending_reg;
    logic [3:0]    phase_reg;
    logic [7:0]    sum_reg;
    logic [14:0]   rem_reg;
    logic [1:0]    link_reg;
    logic [15:0]   idle_reg, timeout_reg;
    logic          timer_reg;
    logic [6:0]    left_reg;

    logic          m_valid_reg;
    logic [1:0]    o_link_reg, o_stat_reg;
    logic [7:0]    o_data_reg;
    logic [2:0]    o_ev_reg;
    logic [8:0]    o_cnt_reg;
    logic          o_last_reg;

    logic          ram_we;
    logic [7:0]    ram_q;

    logic accept, out_free;
    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = (state_reg == sffrf_pkg::ST_IDLE) && out_free;
    assign accept   = s_valid && s_ready;

    sffrf_ram #(.WIDTH(8), .DEPTH(FIFO_DEPTH)) u_ram (
        .aclk    (aclk),
        .wr_en   (ram_we),
        .wr_addr (wp_reg),
        .wr_data (s_rx_byte),
        .rd_addr (rp_reg),
        .rd_data (ram_q)
    );

    // Combinational step of the frame matcher and FIFO bookkeeping.
    logic [AW-1:0] wp_n, rp_n;
    logic [CW-1:0] rd_n, pd_n;
    logic [3:0]    ph_n;
    logic [7:0]    sum_n, want;
    logic [14:0]   rem_n;
    logic [15:0]   full_len;
    logic [1:0]    link_n, stat_n;
    logic [15:0]   idle_n;
    logic          tmr_n, ok, abort, go_read;
    logic [2:0]    ev_n;

    always_comb begin
        wp_n = wp_reg; rp_n = rp_reg; rd_n = readable_reg; pd_n = pending_reg;
        ph_n = phase_reg; sum_n = sum_reg; rem_n = rem_reg; link_n = link_reg;
        idle_n = idle_reg; tmr_n = timer_reg; ev_n = sffrf_pkg::EV_NONE;
        stat_n = sffrf_pkg::RS_NOTREAD; ok = 1'b1; abort = 1'b0; go_read = 1'b0;
        ram_we = 1'b0;
        full_len = {s_rx_byte, 1'b0, rem_reg[6:0]};
        if (link_reg == sffrf_pkg::LINK_NONE) begin
            want = sffrf_pkg::OP_READY;
        end else if (link_reg == sffrf_pkg::LINK_READY) begin
            want = sffrf_pkg::OP_LINK_EST;
        end else begin
            want = phase_reg[3] ? sffrf_pkg::OP_RELEASED : sffrf_pkg::OP_TRANSPARENT;
        end
        case (sffrf_pkg::action_t'(s_action))
            sffrf_pkg::ACT_BYTE: begin
                if (s_framing_error) begin
                    ev_n = sffrf_pkg::EV_NONE;
                end else if (readable_reg + pending_reg >= DEPTH_C) begin
                    ev_n = sffrf_pkg::EV_FULL;
                end else begin
                    if (link_reg != sffrf_pkg::LINK_NONE) begin
                        ram_we = accept;
                        wp_n = (wp_reg == LAST_A) ? '0 : wp_reg + 1'b1;
                        pd_n = pending_reg + 1'b1;
                    end
                    idle_n = '0;
                    case (phase_reg[2:0])
                        3'd0: begin
                            ok = (s_rx_byte == sffrf_pkg::STX_BYTE);
                            if (ok) tmr_n = 1'b1;
                        end
                        3'd1: begin
                            ok = (s_rx_byte == sffrf_pkg::IND_BYTE);
                            sum_n = sum_reg + s_rx_byte;
                        end
                        3'd2: begin
                            ok = (s_rx_byte == want);
                            sum_n = sum_reg + s_rx_byte;
                        end
                        3'd3: begin
                            rem_n = {7'd0, s_rx_byte};
                            sum_n = sum_reg + s_rx_byte;
                        end
                        3'd4: begin
                            full_len = {s_rx_byte, rem_reg[7:0]};
                            sum_n = sum_reg + s_rx_byte;
                            ok = (full_len != 16'd0) && !full_len[15];
                            rem_n = full_len[14:0];
                        end
                        3'd5: ok = (s_rx_byte == sum_reg);
                        3'd6: begin
                            rem_n = rem_reg - 1'b1;
                        end
                        default: ok = (s_rx_byte == sffrf_pkg::ETX_BYTE);
                    endcase
                    if (!ok) begin
                        abort = 1'b1;
                    end else if (phase_reg[2:0] == 3'd6 && rem_n != '0) begin
                        ph_n = phase_reg;
                    end else if (phase_reg[2:0] == 3'd7) begin
                        if (link_reg == sffrf_pkg::LINK_CONN && phase_reg == 4'd7) begin
                            ph_n = 4'd8;
                            sum_n = '0;
                        end else begin
                            link_n = (link_reg == sffrf_pkg::LINK_READY) ?
                                     sffrf_pkg::LINK_CONN : sffrf_pkg::LINK_READY;
                            // Step the write pointer back over the held bytes, modulo depth.
                            wp_n = (CW'(wp_n) >= pd_n) ? AW'(CW'(wp_n) - pd_n) :
                                   AW'(CW'(wp_n) + DEPTH_C - pd_n);
                            pd_n = '0;
                            ph_n = '0; sum_n = '0; rem_n = '0; idle_n = '0; tmr_n = 1'b0;
                            ev_n = sffrf_pkg::EV_ACCEPT;
                        end
                    end else begin
                        ph_n = phase_reg + 1'b1;
                    end
                end
            end
            sffrf_pkg::ACT_TICK: begin
                if (timer_reg) begin
                    if (idle_reg != 16'hFFFF) idle_n = idle_reg + 1'b1;
                    if (idle_n >= timeout_reg) abort = 1'b1;
                end
            end
            sffrf_pkg::ACT_READ: begin
                if (link_reg != sffrf_pkg::LINK_CONN) begin
                    stat_n = sffrf_pkg::RS_NOCONN;
                end else if (s_read_count == '0 || s_read_count > sffrf_pkg::READ_MAX
                             || CW'(s_read_count) > readable_reg) begin
                    stat_n = sffrf_pkg::RS_FEW;
                end else begin
                    stat_n = sffrf_pkg::RS_OK;
                    go_read = 1'b1;
                    rd_n = readable_reg - CW'(s_read_count);
                end
            end
            default: stat_n = sffrf_pkg::RS_NOTREAD;
        endcase
        // Abort of a match: release pending bytes, or report a startup error.
        if (abort) begin
            if (link_reg == sffrf_pkg::LINK_NONE) begin
                ev_n = sffrf_pkg::EV_STARTUP;
            end else begin
                rd_n = readable_reg + pd_n;
                pd_n = '0;
                ev_n = sffrf_pkg::EV_RELEASE;
            end
            ph_n = '0; sum_n = '0; rem_n = '0; idle_n = '0; tmr_n = 1'b0;
        end
    end

    // Sequencer next state.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            sffrf_pkg::ST_IDLE: if (accept && go_read) state_next = sffrf_pkg::ST_READ;
            sffrf_pkg::ST_READ: if (out_free && left_reg == 7'd1) state_next = sffrf_pkg::ST_OUT;
            sffrf_pkg::ST_OUT:  if (out_free) state_next = sffrf_pkg::ST_IDLE;
            default:            state_next = sffrf_pkg::ST_IDLE;
        endcase
    end

    // Read streaming: the RAM output is registered, so it is valid the cycle after the address moves.
    logic pop, have_q;
    logic have_q_reg;
    assign pop    = (state_reg == sffrf_pkg::ST_READ) && out_free && have_q_reg;
    assign have_q = (state_reg == sffrf_pkg::ST_READ) && !pop;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= sffrf_pkg::ST_IDLE;
            wp_reg <= '0; rp_reg <= '0; readable_reg <= '0; pending_reg <= '0;
            phase_reg <= '0; sum_reg <= '0; rem_reg <= '0; link_reg <= '0;
            idle_reg <= '0; timer_reg <= 1'b0; timeout_reg <= sffrf_pkg::TIMEOUT_RESET;
            m_valid_reg <= 1'b0; left_reg <= '0; have_q_reg <= 1'b0;
        end else begin
            if (cfg_we) timeout_reg <= cfg_wdata;
            if (m_valid_reg && m_ready) m_valid_reg <= 1'b0;
            have_q_reg <= (state_reg == sffrf_pkg::ST_READ) ? (have_q || pop) : 1'b0;
            if (accept) begin
                wp_reg <= wp_n; readable_reg <= rd_n; pending_reg <= pd_n;
                phase_reg <= ph_n; sum_reg <= sum_n; rem_reg <= rem_n;
                link_reg <= link_n; idle_reg <= idle_n; timer_reg <= tmr_n;
                left_reg <= s_read_count;
                if (!go_read) begin
                    m_valid_reg <= 1'b1;
                    o_link_reg <= link_n; o_data_reg <= '0; o_stat_reg <= stat_n;
                    o_ev_reg <= ev_n; o_cnt_reg <= 9'(rd_n); o_last_reg <= 1'b1;
                end
            end
            if (pop) begin
                m_valid_reg <= 1'b1;
                o_link_reg <= link_reg; o_data_reg <= ram_q;
                o_stat_reg <= sffrf_pkg::RS_OK; o_ev_reg <= sffrf_pkg::EV_NONE;
                o_cnt_reg <= 9'(readable_reg); o_last_reg <= (left_reg == 7'd1);
                left_reg <= left_reg - 1'b1;
                rp_reg <= (rp_reg == LAST_A) ? '0 : rp_reg + 1'b1;
                have_q_reg <= 1'b0;
            end
            state_reg <= (state_reg == sffrf_pkg::ST_READ && !pop) ? state_reg :
                         (state_reg == sffrf_pkg::ST_OUT) ? sffrf_pkg::ST_IDLE : state_next;
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_link_state     = o_link_reg;
    assign m_read_data      = o_data_reg;
    assign m_read_status    = o_stat_reg;
    assign m_event_res      = o_ev_reg;
    assign m_readable_count = o_cnt_reg;
    assign m_last           = o_last_reg;
endmodule
